// ===== hw/rtl/bsmw_pkg.sv =====
// Shared types and constants for the bounded-step max walk engine.
`default_nettype none

package bsmw_pkg;

   localparam int NODE_ID_BITS    = 10;
   localparam int POINTS_BITS     = 32;
   localparam int NODE_COUNT_BITS = 11;
   localparam int TARGET_BITS     = 48;
   localparam int MOVES_BITS      = 12;
   localparam int REQ_DATA_BITS   = 56;
   localparam int RSP_DATA_BITS   = 16;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 48;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_NODE_COUNT   = 2'd0,
      CSR_TARGET_SCORE = 2'd1,
      CSR_MAX_MOVES    = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_LOAD,
      ST_MARK,
      ST_EDGES,
      ST_NODES,
      ST_FINISH
   } state_type;

   // source in the lowest bits, as packed on the request bus
   typedef struct packed {
      logic [POINTS_BITS-1:0]  points;
      logic [NODE_ID_BITS-1:0] dst;
      logic [NODE_ID_BITS-1:0] src;
   } edge_rec_type;

endpackage

`default_nettype wire

// ===== hw/rtl/bsmw_ram.sv =====
// Generic one-write one-read RAM with registered read data (old data on collision).
`default_nettype none

module bsmw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/bounded_step_max_walk_dp.sv =====
// Top level: edge loader and max-plus bounded walk solver over block RAMs.
//
//  channel  | direction | payload
//  ---------+-----------+------------------------------------------------------------
//  req      | in        | tuser edge_valid; tdata edge_from/to/points; tlast last_edge
//  rsp      | out       | tdata: reachable, moves_needed
//  csr      | in        | csr_index selects node_count / target_score / max_moves
//
// Edges load at one request per cycle while in the load state. After the last request,
// unless max_moves is zero, the solver runs a marking sweep over the E stored edges,
// then per move count an edge sweep over the E stored edges and a node sweep over
// the N nodes, N = clamped node count. The answer is followed by a clearing pass
// over the N nodes. After reset a clearing pass over all MAX_NODES entries runs
// before the first request is taken.
// A pending response does not stall loading of the next graph; it holds its answer.
`default_nettype none

module bounded_step_max_walk_dp #(
   parameter int MAX_NODES  = 1024,
   parameter int MAX_EDGES  = 4096,
   parameter int SCORE_BITS = 48
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // [9:0] edge_from, [19:10] edge_to, [51:20] edge_points, [55:52] zero
   input  wire logic [bsmw_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // [0] edge_valid
   input  wire logic                                 req_tuser,
   input  wire logic                                 req_tlast,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // [0] reachable, [12:1] moves_needed, [15:13] zero
   output logic      [bsmw_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [bsmw_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [bsmw_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   import bsmw_pkg::*;

   localparam int EAW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int ECW   = $clog2(MAX_EDGES + 1);
   localparam int NAW   = $clog2(MAX_NODES);
   localparam int NCW   = $clog2(MAX_NODES + 1);
   localparam int CW    = (NCW > NODE_ID_BITS) ? NCW : NODE_ID_BITS;
   localparam int CLW   = (NCW > NODE_COUNT_BITS) ? NCW : NODE_COUNT_BITS;
   localparam int SUM_W = ((SCORE_BITS > POINTS_BITS) ? SCORE_BITS : POINTS_BITS) + 1;
   localparam int TW    = (SCORE_BITS > TARGET_BITS) ? SCORE_BITS : TARGET_BITS;
   localparam int ERW   = $bits(edge_rec_type);

   localparam logic [SCORE_BITS-1:0] SCORE_MAX = {SCORE_BITS{1'b1}};

   // control
   state_type                state_ff, state_in;
   logic [ECW-1:0]           ecnt_ff, ecnt_in;
   logic [ECW-1:0]           erd_ff, erd_in;
   logic [NCW-1:0]           nidx_ff, nidx_in;
   logic [NCW-1:0]           nodes_ff, nodes_in;
   logic [MOVES_BITS-1:0]    jcnt_ff, jcnt_in;
   logic                     full_clr_ff, full_clr_in;
   logic                     hit_ff, hit_in;
   logic                     s1_ff, s1_in;
   logic                     s2_ff, s2_in;
   logic                     fw_en_ff, fw_en_in;
   logic                     n1_ff, n1_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // configuration
   logic [NODE_COUNT_BITS-1:0] node_count_ff;
   logic [TARGET_BITS-1:0]     target_ff;
   logic [MOVES_BITS-1:0]      max_moves_ff;

   // payload
   logic [NAW-1:0]           s2_src_ff, s2_src_in;
   logic [POINTS_BITS-1:0]   s2_pts_ff, s2_pts_in;
   logic [NAW-1:0]           fw_addr_ff, fw_addr_in;
   logic [SCORE_BITS-1:0]    fw_data_ff, fw_data_in;
   logic [NAW-1:0]           n1_addr_ff, n1_addr_in;
   logic [SCORE_BITS-1:0]    cur0_ff, cur0_in;
   logic                     rsp_reach_ff, rsp_reach_in;
   logic [MOVES_BITS-1:0]    rsp_moves_ff, rsp_moves_in;

   // memory ports
   logic                     ed_we;
   edge_rec_type             ed_wdata, ed_rdata;
   logic [ERW-1:0]           ed_rdata_raw;
   logic                     prev_we, cur_we, hout_we;
   logic [NAW-1:0]           prev_waddr, cur_waddr, hout_waddr;
   logic [SCORE_BITS-1:0]    prev_wdata, cur_wdata;
   logic                     hout_wdata;
   logic [NAW-1:0]           prev_raddr, cur_raddr, hout_raddr;
   logic [SCORE_BITS-1:0]    prev_rdata, cur_rdata;
   logic                     hout_rdata;

   // datapath
   logic                     req_acc;
   logic [CLW-1:0]           ncount_x;
   logic [NCW-1:0]           nodes_clamp;
   logic [CW-1:0]            src_x, dst_x, nodes_x;
   logic                     in_rng;
   logic [SCORE_BITS-1:0]    cur_old, cand, best;
   logic [SUM_W-1:0]         sum;
   logic [SCORE_BITS-1:0]    node_c0, node_val;
   logic [NCW-1:0]           clr_lim;

   bsmw_ram #(.WIDTH(ERW), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock   (clock),
      .wr_en   (ed_we),
      .wr_addr (ecnt_ff[EAW-1:0]),
      .wr_data (ed_wdata),
      .rd_addr (erd_ff[EAW-1:0]),
      .rd_data (ed_rdata_raw)
   );

   bsmw_ram #(.WIDTH(SCORE_BITS), .DEPTH(MAX_NODES)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (prev_waddr),
      .wr_data (prev_wdata),
      .rd_addr (prev_raddr),
      .rd_data (prev_rdata)
   );

   bsmw_ram #(.WIDTH(SCORE_BITS), .DEPTH(MAX_NODES)) u_cur_ram (
      .clock   (clock),
      .wr_en   (cur_we),
      .wr_addr (cur_waddr),
      .wr_data (cur_wdata),
      .rd_addr (cur_raddr),
      .rd_data (cur_rdata)
   );

   bsmw_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_hout_ram (
      .clock   (clock),
      .wr_en   (hout_we),
      .wr_addr (hout_waddr),
      .wr_data (hout_wdata),
      .rd_addr (hout_raddr),
      .rd_data (hout_rdata)
   );

   assign ed_rdata   = edge_rec_type'(ed_rdata_raw);
   assign ed_wdata   = edge_rec_type'(req_tdata[ERW-1:0]);
   assign req_tready = (state_ff == ST_LOAD);
   assign req_acc    = req_tvalid && req_tready;
   assign ed_we      = req_acc && req_tuser && (ecnt_ff < ECW'(MAX_EDGES));
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({rsp_moves_ff, rsp_reach_ff});

   // node count 0 acts as 1, beyond the node store acts as its size
   always_comb begin
      ncount_x = CLW'(node_count_ff);
      if (ncount_x == '0) begin
         nodes_clamp = NCW'(1);
      end else if (ncount_x > CLW'(MAX_NODES)) begin
         nodes_clamp = NCW'(MAX_NODES);
      end else begin
         nodes_clamp = NCW'(ncount_x);
      end
   end

   assign src_x   = CW'(ed_rdata.src);
   assign dst_x   = CW'(ed_rdata.dst);
   assign nodes_x = CW'(nodes_ff);
   assign in_rng  = (src_x < nodes_x) && (dst_x < nodes_x);

   // edge relaxation; the write of the previous cycle is not yet visible in the RAM
   assign cur_old = (fw_en_ff && (fw_addr_ff == s2_src_ff)) ? fw_data_ff : cur_rdata;
   assign sum     = SUM_W'(s2_pts_ff) + SUM_W'(prev_rdata);
   assign cand    = (|sum[SUM_W-1:SCORE_BITS]) ? SCORE_MAX : sum[SCORE_BITS-1:0];
   assign best    = (cand > cur_old) ? cand : cur_old;

   // node pass: a node without out-edges takes node 0's score
   assign node_c0  = (n1_addr_ff == '0) ? cur_rdata : cur0_ff;
   assign node_val = hout_rdata ? cur_rdata : node_c0;

   assign clr_lim = full_clr_ff ? NCW'(MAX_NODES) : nodes_ff;

   assign prev_raddr = NAW'(ed_rdata.dst);
   assign cur_raddr  = (state_ff == ST_NODES) ? nidx_ff[NAW-1:0] : NAW'(ed_rdata.src);
   assign hout_raddr = nidx_ff[NAW-1:0];

   always_comb begin
      state_in     = state_ff;
      ecnt_in      = ecnt_ff;
      erd_in       = erd_ff;
      nidx_in      = nidx_ff;
      nodes_in     = nodes_ff;
      jcnt_in      = jcnt_ff;
      full_clr_in  = full_clr_ff;
      hit_in       = hit_ff;
      s1_in        = 1'b0;
      s2_in        = 1'b0;
      fw_en_in     = 1'b0;
      n1_in        = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      s2_src_in    = NAW'(ed_rdata.src);
      s2_pts_in    = ed_rdata.points;
      fw_addr_in   = s2_src_ff;
      fw_data_in   = best;
      n1_addr_in   = nidx_ff[NAW-1:0];
      cur0_in      = cur0_ff;
      rsp_reach_in = rsp_reach_ff;
      rsp_moves_in = rsp_moves_ff;
      prev_we      = 1'b0;
      prev_waddr   = n1_addr_ff;
      prev_wdata   = node_val;
      cur_we       = 1'b0;
      cur_waddr    = s2_src_ff;
      cur_wdata    = best;
      hout_we      = 1'b0;
      hout_waddr   = NAW'(ed_rdata.src);
      hout_wdata   = 1'b1;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            if (nidx_ff < clr_lim) begin
               prev_we    = 1'b1;
               prev_waddr = nidx_ff[NAW-1:0];
               prev_wdata = '0;
               cur_we     = 1'b1;
               cur_waddr  = nidx_ff[NAW-1:0];
               cur_wdata  = '0;
               hout_we    = 1'b1;
               hout_waddr = nidx_ff[NAW-1:0];
               hout_wdata = 1'b0;
               nidx_in    = nidx_ff + NCW'(1);
            end else begin
               full_clr_in = 1'b0;
               state_in    = ST_LOAD;
            end
         end

         ST_LOAD: begin
            if (ed_we) begin
               ecnt_in = ecnt_ff + ECW'(1);
            end
            if (req_acc && req_tlast) begin
               nodes_in = nodes_clamp;
               hit_in   = 1'b0;
               jcnt_in  = MOVES_BITS'(1);
               erd_in   = '0;
               state_in = (max_moves_ff == '0) ? ST_FINISH : ST_MARK;
            end
         end

         ST_MARK: begin
            if (erd_ff < ecnt_ff) begin
               s1_in  = 1'b1;
               erd_in = erd_ff + ECW'(1);
            end
            if (s1_ff && in_rng) begin
               hout_we = 1'b1;
            end
            if ((erd_ff == ecnt_ff) && !s1_ff) begin
               erd_in   = '0;
               state_in = ST_EDGES;
            end
         end

         ST_EDGES: begin
            if (erd_ff < ecnt_ff) begin
               s1_in  = 1'b1;
               erd_in = erd_ff + ECW'(1);
            end
            s2_in = s1_ff && in_rng;
            if (s2_ff) begin
               cur_we   = 1'b1;
               fw_en_in = 1'b1;
            end
            if ((erd_ff == ecnt_ff) && !s1_ff && !s2_ff) begin
               nidx_in  = '0;
               state_in = ST_NODES;
            end
         end

         ST_NODES: begin
            if (nidx_ff < nodes_ff) begin
               n1_in   = 1'b1;
               nidx_in = nidx_ff + NCW'(1);
            end
            if (n1_ff) begin
               // fold the copy to the previous row and the clear of the current row
               prev_we   = 1'b1;
               cur_we    = 1'b1;
               cur_waddr = n1_addr_ff;
               cur_wdata = '0;
               if (n1_addr_ff == '0) begin
                  cur0_in = cur_rdata;
                  hit_in  = hout_rdata && (TW'(cur_rdata) >= TW'(target_ff));
               end
            end
            if ((nidx_ff == nodes_ff) && !n1_ff) begin
               if (hit_ff || (jcnt_ff == max_moves_ff)) begin
                  state_in = ST_FINISH;
               end else begin
                  jcnt_in  = jcnt_ff + MOVES_BITS'(1);
                  erd_in   = '0;
                  state_in = ST_EDGES;
               end
            end
         end

         ST_FINISH: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_reach_in = hit_ff;
               rsp_moves_in = hit_ff ? jcnt_ff : '0;
               ecnt_in      = '0;
               nidx_in      = '0;
               state_in     = ST_CLEAR;
            end
         end

         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ecnt_ff      <= '0;
         erd_ff       <= '0;
         nidx_ff      <= '0;
         nodes_ff     <= NCW'(1);
         jcnt_ff      <= '0;
         full_clr_ff  <= 1'b1;
         hit_ff       <= 1'b0;
         s1_ff        <= 1'b0;
         s2_ff        <= 1'b0;
         fw_en_ff     <= 1'b0;
         n1_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ecnt_ff      <= ecnt_in;
         erd_ff       <= erd_in;
         nidx_ff      <= nidx_in;
         nodes_ff     <= nodes_in;
         jcnt_ff      <= jcnt_in;
         full_clr_ff  <= full_clr_in;
         hit_ff       <= hit_in;
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         fw_en_ff     <= fw_en_in;
         n1_ff        <= n1_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_BITS'(1);
         target_ff     <= '0;
         max_moves_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_NODE_COUNT:   node_count_ff <= csr_data[NODE_COUNT_BITS-1:0];
            CSR_TARGET_SCORE: target_ff     <= csr_data[TARGET_BITS-1:0];
            CSR_MAX_MOVES:    max_moves_ff  <= csr_data[MOVES_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      s2_src_ff    <= s2_src_in;
      s2_pts_ff    <= s2_pts_in;
      fw_addr_ff   <= fw_addr_in;
      fw_data_ff   <= fw_data_in;
      n1_addr_ff   <= n1_addr_in;
      cur0_ff      <= cur0_in;
      rsp_reach_ff <= rsp_reach_in;
      rsp_moves_ff <= rsp_moves_in;
   end

`ifndef SYNTHESIS
   a_edge_write_in_load: assert property (@(posedge clock) disable iff (reset)
      ed_we |-> (state_ff == ST_LOAD))
      else $error("edge RAM written outside load");

   a_relax_only_in_edges: assert property (@(posedge clock) disable iff (reset)
      s2_ff |-> (state_ff == ST_EDGES))
      else $error("relaxation stage active outside edge sweep");

   a_edge_count_bound: assert property (@(posedge clock) disable iff (reset)
      ecnt_ff <= ECW'(MAX_EDGES))
      else $error("edge count beyond store depth");

   a_unreachable_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_reach_ff) |-> (rsp_moves_ff == '0))
      else $error("unreachable response with nonzero move count");

   a_node_write_in_range: assert property (@(posedge clock) disable iff (reset)
      n1_ff |-> (NCW'(n1_addr_ff) < nodes_ff))
      else $error("node pass beyond node count");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_bounded_step_max_walk_dp.sv =====
// Self-checking testbench for the bounded-step max walk solver: graph loading, answers, registers.
`timescale 1ns / 1ps

module tb_bounded_step_max_walk_dp;
   import bsmw_pkg::*;

   localparam int MAX_NODES        = 1024;
   localparam int MAX_EDGES        = 4096;
   localparam int SCORE_BITS       = 48;
   localparam int SETTLE_CYCLES    = MAX_NODES + 32;
   localparam int WATCHDOG_LIMIT   = 200000;
   localparam int LONG_HOLD_CYCLES = 800;
   localparam int RANDOM_ITEMS     = 600;

   localparam logic [SCORE_BITS-1:0] SCORE_MAX = '1;

   typedef struct packed {
      logic                    edge_valid;
      logic [NODE_ID_BITS-1:0] src;
      logic [NODE_ID_BITS-1:0] dst;
      logic [POINTS_BITS-1:0]  points;
      logic                    last;
   } edge_req_type;

   typedef struct packed {
      logic                  reachable;
      logic [MOVES_BITS-1:0] moves;
   } walk_answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [REQ_DATA_BITS-1:0]     req_tdata  = '0;
   logic                         req_tuser  = 1'b0;
   logic                         req_tlast  = 1'b0;
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0]     rsp_tdata;
   logic                         csr_valid  = 1'b0;
   logic                         csr_ready;
   csr_index_type                csr_index  = CSR_NODE_COUNT;
   logic [CSR_DATA_BITS-1:0]     csr_data   = '0;

   bounded_step_max_walk_dp u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   // register shadow, written only by the stimulus process
   logic [NODE_COUNT_BITS-1:0] set_nodes  = 11'd1;
   logic [TARGET_BITS-1:0]     set_target = '0;
   logic [MOVES_BITS-1:0]      set_moves  = '0;

   // graph shadow
   logic [NODE_ID_BITS-1:0] graph_src [MAX_EDGES];
   logic [NODE_ID_BITS-1:0] graph_dst [MAX_EDGES];
   logic [POINTS_BITS-1:0]  graph_pts [MAX_EDGES];
   int unsigned             graph_edges = 0;
   logic                    has_exit   [MAX_NODES];
   logic [SCORE_BITS-1:0]   score_prev [MAX_NODES];
   logic [SCORE_BITS-1:0]   score_cur  [MAX_NODES];

   edge_req_type    pending_edges [$];
   walk_answer_type expected_answers [$];

   logic        req_burst       = 1'b0;
   logic        rsp_burst       = 1'b0;
   logic        long_hold_armed = 1'b0;
   int unsigned error_count     = 0;
   int unsigned requests_taken  = 0;
   int unsigned answers_seen    = 0;
   int unsigned reachable_seen  = 0;
   int unsigned settings_used   = 0;
   int unsigned stim_items      = 0;

   // smallest move count whose node 0 score meets the target while node 0 has an in-range out-edge, 0 if none
   function automatic logic [MOVES_BITS-1:0] fewest_moves();
      int unsigned           nodes;
      logic [SCORE_BITS:0]   sum;
      logic [SCORE_BITS-1:0] cand;
      nodes = (set_nodes == 0) ? 1 : (set_nodes > MAX_NODES) ? MAX_NODES : set_nodes;
      for (int i = 0; i < nodes; i++) begin
         has_exit[i]   = 1'b0;
         score_prev[i] = '0;
      end
      for (int e = 0; e < graph_edges; e++)
         if (graph_src[e] < nodes && graph_dst[e] < nodes)
            has_exit[graph_src[e]] = 1'b1;
      for (int j = 1; j <= set_moves; j++) begin
         for (int i = 0; i < nodes; i++)
            score_cur[i] = '0;
         for (int e = 0; e < graph_edges; e++) begin
            if (graph_src[e] >= nodes || graph_dst[e] >= nodes)
               continue;
            sum  = {1'b0, score_prev[graph_dst[e]]} + graph_pts[e];
            cand = sum[SCORE_BITS] ? SCORE_MAX : sum[SCORE_BITS-1:0];
            if (cand > score_cur[graph_src[e]])
               score_cur[graph_src[e]] = cand;
         end
         // dead ends return to the start for free
         for (int i = 0; i < nodes; i++)
            if (!has_exit[i])
               score_cur[i] = score_cur[0];
         if (has_exit[0] && score_cur[0] >= set_target)
            return MOVES_BITS'(j);
         for (int i = 0; i < nodes; i++)
            score_prev[i] = score_cur[i];
      end
      return '0;
   endfunction

   function automatic void absorb_request(input edge_req_type r);
      walk_answer_type ans;
      if (r.edge_valid && graph_edges < MAX_EDGES) begin
         graph_src[graph_edges] = r.src;
         graph_dst[graph_edges] = r.dst;
         graph_pts[graph_edges] = r.points;
         graph_edges++;
      end
      if (r.last) begin
         ans.moves     = fewest_moves();
         ans.reachable = (ans.moves != 0);
         expected_answers.push_back(ans);
         graph_edges = 0;
      end
   endfunction

   function automatic void flag_error(input string msg);
      error_count++;
      if (error_count <= 10)
         $display("[%0t] ERROR %s", $realtime, msg);
   endfunction

   // request driver
   edge_req_type req_item;
   int unsigned  req_gap = 0;

   always @(posedge clock) begin
      edge_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap    <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            absorb_request(req_item);
            requests_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap != 0) begin
               req_gap    <= req_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_edges.size() != 0) begin
               nxt = pending_edges.pop_front();
               req_item   <= nxt;
               req_tdata  <= {4'b0, nxt.points, nxt.dst, nxt.src};
               req_tuser  <= nxt.edge_valid;
               req_tlast  <= nxt.last;
               req_tvalid <= 1'b1;
               req_gap    <= req_burst ? 0 : $urandom_range(0, 12);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // answer monitor
   int unsigned rsp_wait   = 0;
   int unsigned hold_count = 0;

   always @(posedge clock) begin
      int unsigned     next_wait;
      logic            holding;
      walk_answer_type want;
      walk_answer_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait   <= 0;
      end else begin
         next_wait = rsp_wait;
         if (rsp_tvalid && rsp_tready) begin
            got.reachable = rsp_tdata[0];
            got.moves     = rsp_tdata[12:1];
            answers_seen++;
            if (got.reachable)
               reachable_seen++;
            if (expected_answers.size() == 0) begin
               flag_error($sformatf("unexpected answer reachable=%0d moves=%0d",
                                    got.reachable, got.moves));
            end else begin
               want = expected_answers.pop_front();
               if (got.reachable !== want.reachable || got.moves !== want.moves)
                  flag_error($sformatf({"answer %0d: expected reachable=%0d moves=%0d,",
                                        " got reachable=%0d moves=%0d"}, answers_seen,
                                       want.reachable, want.moves,
                                       got.reachable, got.moves));
            end
            next_wait = rsp_burst ? 0 : $urandom_range(0, 12);
         end else if (rsp_tvalid && next_wait != 0) begin
            next_wait--;
         end
         // the long hold counts only while an answer is waiting
         holding = long_hold_armed && hold_count < LONG_HOLD_CYCLES;
         if (holding && rsp_tvalid)
            hold_count <= hold_count + 1;
         rsp_wait   <= next_wait;
         rsp_tready <= !holding && next_wait == 0;
      end
   end

   // watchdog on handshake progress
   int unsigned stall_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("status: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_NODE_COUNT:   set_nodes  = value[NODE_COUNT_BITS-1:0];
         CSR_TARGET_SCORE: set_target = value[TARGET_BITS-1:0];
         CSR_MAX_MOVES:    set_moves  = value[MOVES_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [NODE_COUNT_BITS-1:0] nodes,
                                 input logic [TARGET_BITS-1:0] target,
                                 input logic [MOVES_BITS-1:0] moves);
      write_reg(CSR_NODE_COUNT, CSR_DATA_BITS'(nodes));
      write_reg(CSR_TARGET_SCORE, CSR_DATA_BITS'(target));
      write_reg(CSR_MAX_MOVES, CSR_DATA_BITS'(moves));
      settings_used++;
      @(negedge clock);
   endtask

   // drained and past the clearing pass
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_edges.size() != 0 || req_tvalid || expected_answers.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic offer(input logic valid, input logic [NODE_ID_BITS-1:0] src,
                        input logic [NODE_ID_BITS-1:0] dst,
                        input logic [POINTS_BITS-1:0] points, input logic last);
      edge_req_type it;
      it.edge_valid = valid;
      it.src        = src;
      it.dst        = dst;
      it.points     = points;
      it.last       = last;
      pending_edges.push_back(it);
   endtask

   task automatic push_graph(input int unsigned span);
      int unsigned             n_edges;
      logic                    wide_pts;
      logic                    empty_close;
      logic [NODE_ID_BITS-1:0] src;
      logic [NODE_ID_BITS-1:0] dst;
      n_edges     = $urandom_range(1, 12);
      wide_pts    = $urandom_range(0, 1);
      empty_close = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < n_edges; k++) begin
         if ($urandom_range(0, 9) == 0)
            offer(1'b0, NODE_ID_BITS'($urandom), NODE_ID_BITS'($urandom), $urandom, 1'b0);
         if ($urandom_range(0, 11) == 0) begin
            src = NODE_ID_BITS'($urandom);
            dst = NODE_ID_BITS'($urandom);
         end else begin
            src = ($urandom_range(0, 3) == 0) ? '0 : NODE_ID_BITS'($urandom_range(0, span - 1));
            dst = NODE_ID_BITS'($urandom_range(0, span - 1));
         end
         offer(1'b1, src, dst, wide_pts ? $urandom : $urandom_range(0, 300),
               !empty_close && k == n_edges - 1);
         stim_items++;
      end
      if (empty_close) begin
         offer(1'b0, NODE_ID_BITS'($urandom), NODE_ID_BITS'($urandom), $urandom, 1'b1);
         stim_items++;
      end
   endtask

   initial begin
      logic [NODE_COUNT_BITS-1:0] nodes;
      logic [TARGET_BITS-1:0]     target;
      logic [MOVES_BITS-1:0]      moves;
      int unsigned                span;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      wait_idle();

      // power-up registers: zero moves never reach
      offer(1'b1, 10'd0, 10'd0, 32'd5, 1'b1);
      wait_idle();

      apply_settings(11'd4, '0, 12'd3);
      offer(1'b0, 10'd0, 10'd0, 32'd0, 1'b1);               // start node has no edges
      offer(1'b1, 10'd0, 10'd1, 32'hFFFF_FFFF, 1'b0);
      offer(1'b0, 10'h3FF, 10'h3FF, 32'hFFFF_FFFF, 1'b0);   // empty, stores nothing
      offer(1'b1, 10'd1, 10'd0, 32'd0, 1'b0);
      offer(1'b1, 10'h3FF, 10'd0, 32'd7, 1'b0);             // unused nodes, ignored
      offer(1'b1, 10'd0, 10'h3FF, 32'd9, 1'b0);
      offer(1'b1, 10'd3, 10'd2, 32'd1, 1'b1);
      wait_idle();

      // dead-end node 1 mirrors node 0, answer after three moves
      apply_settings(11'd4, 48'd25, 12'd3);
      offer(1'b1, 10'd0, 10'd1, 32'd10, 1'b1);
      wait_idle();

      // node count 0 behaves as 1; unreachable target
      apply_settings(11'd0, 48'hFFFF_FFFF_FFFF, 12'd2);
      offer(1'b1, 10'd0, 10'd0, 32'hFFFF_FFFF, 1'b1);
      wait_idle();

      // oversize node count clamps to the full graph
      apply_settings(11'd2047, 48'h2_FFFF_FFFD, 12'd4095);
      offer(1'b1, 10'd0, 10'h3FF, 32'hFFFF_FFFF, 1'b0);
      offer(1'b1, 10'h3FF, 10'd0, 32'hFFFF_FFFF, 1'b0);
      offer(1'b1, 10'h2AA, 10'h155, 32'hAAAA_AAAA, 1'b0);
      offer(1'b1, 10'h155, 10'h2AA, 32'h5555_5555, 1'b0);
      offer(1'b0, 10'd0, 10'd0, 32'd0, 1'b1);
      wait_idle();

      // full move budget exhausted without reaching
      apply_settings(11'd2, 48'hFFFF_FFFF_FFFF, 12'd4095);
      offer(1'b1, 10'd0, 10'd1, 32'hFFFF_FFFF, 1'b0);
      offer(1'b1, 10'd1, 10'd0, 32'hFFFF_FFFF, 1'b1);
      wait_idle();

      // answers back up while the sender keeps streaming small graphs
      apply_settings(11'd6, '1, 12'd6);
      long_hold_armed = 1'b1;
      req_burst       = 1'b1;
      rsp_burst       = 1'b1;
      repeat (4)
         push_graph(6);
      wait_idle();

      while (stim_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       nodes = 11'd1024;
            1:       nodes = NODE_COUNT_BITS'($urandom_range(0, 2047));
            default: nodes = NODE_COUNT_BITS'($urandom_range(1, 12));
         endcase
         span = (nodes == 0) ? 1 : (nodes > MAX_NODES) ? MAX_NODES : nodes;
         if ($urandom_range(0, 7) == 0)
            moves = '0;
         else
            moves = MOVES_BITS'((span > 64) ? $urandom_range(1, 4) : $urandom_range(1, 30));
         case ($urandom_range(0, 4))
            0:       target = '0;
            1:       target = TARGET_BITS'($urandom_range(0, 500));
            2:       target = TARGET_BITS'($urandom_range(0, 5000));
            3:       target = TARGET_BITS'({$urandom, $urandom}) >> $urandom_range(0, 47);
            default: target = '1;
         endcase
         apply_settings(nodes, target, moves);
         req_burst = ($urandom_range(0, 3) == 0);
         rsp_burst = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(4, 10))
            push_graph(span);
         wait_idle();
      end

      $display("covered %0d requests under %0d register settings, with a long answer stall",
               requests_taken, settings_used);
      $display("checked %0d answers, %0d reachable", answers_seen, reachable_seen);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", error_count);
         $display("status: fail");
      end
      $finish;
   end

endmodule
